@@ rtl/core/cubic_peak_interpolator_unit_macros.svh @@
// -----------------------------------------------------------------------------
// Cubic peak interpolator assertion macros
// Shared concurrent assertion forms for the checker.
// -----------------------------------------------------------------------------
`ifndef CUBIC_PEAK_INTERPOLATOR_UNIT_MACROS_SVH
`define CUBIC_PEAK_INTERPOLATOR_UNIT_MACROS_SVH

// same-cycle implication
`define CPI_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpi check failed");

// implication after a fixed number of cycles
`define CPI_ASSERT_DELAY(label, clk, rst, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("cpi check failed");

`endif

@@ rtl/core/cpi_pkg.sv @@
// -----------------------------------------------------------------------------
// Cubic peak interpolator package
// Types, widths, status codes and pipeline depth.
// -----------------------------------------------------------------------------
package cpi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SAMPLE_W      = 32;
  localparam int COEF_W        = 38;
  localparam int HALF_W        = 19;
  localparam int PROD_W        = 2 * (COEF_W - 1);
  localparam int P_W           = 78;
  localparam int SQ_W          = 124;
  localparam int ROOT_W        = 61;
  localparam int SQRT_STEPS    = 61;
  localparam int NUM_W         = 64;
  localparam int DEN_W         = 36;
  localparam int DIV_STEPS     = 64;
  localparam int LATENCY       = 4 + SQRT_STEPS + 1 + DIV_STEPS + 1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FLAT    = 2'd1;
  localparam logic [1:0] ST_COMPLEX = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
    logic signed [SAMPLE_W-1:0] sample_2;
    logic signed [SAMPLE_W-1:0] sample_3;
  } samples_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] peak_offset;
    logic [1:0]                 fit_status;
  } result_t;

  function automatic logic [COEF_W-2:0] mag(input logic signed [COEF_W-1:0] v);
    logic signed [COEF_W-1:0] n;
    n = -v;
    return v[COEF_W-1] ? n[COEF_W-2:0] : v[COEF_W-2:0];
  endfunction

endpackage

@@ rtl/core/cubic_peak_interpolator_unit.sv @@
// -----------------------------------------------------------------------------
// Cubic peak interpolator
// Fits a cubic through four samples and returns the maximum position.
// -----------------------------------------------------------------------------
// channel   | handshake      | payload
// input     | start / busy   | samples (samples_t)
// result    | done (strobe)  | result  (result_t)
//
// Fully pipelined: one transaction per cycle. Depth is set by the bit-per-stage
// square root (61 stages) and the bit-per-stage divider (64 stages). busy is
// never raised.
// Synchronous reset clears all stage valid bits; in-flight items are dropped.
// -----------------------------------------------------------------------------
module cubic_peak_interpolator_unit
  import cpi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  samples_t samples,
  output result_t  result,
  output logic     done
);

  assign busy = 1'b0;

  // stage 1: coefficients
  logic                     v1;
  logic signed [COEF_W-1:0] a1, b1, c1;
  logic signed [COEF_W-1:0] s0, s1, s2, s3;

  always_comb begin
    s0 = COEF_W'(samples.sample_0);
    s1 = COEF_W'(samples.sample_1);
    s2 = COEF_W'(samples.sample_2);
    s3 = COEF_W'(samples.sample_3);
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    a1 <= -s0 + 3 * s1 - 3 * s2 + s3;
    b1 <= 2 * s0 - 5 * s1 + 4 * s2 - s3;
    c1 <= -11 * s0 + 18 * s1 - 9 * s2 + 2 * s3;
  end

  // stage 2: partial products
  logic                     v2, acadd2;
  logic signed [COEF_W-1:0] a2, b2;
  logic [PROD_W-1:0]        bb_lo, bb_hi, ac_lo, ac_hi;
  logic [COEF_W-2:0]        bm1, am1, cm1;

  always_comb begin
    bm1 = mag(b1);
    am1 = mag(a1);
    cm1 = mag(c1);
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    a2     <= a1;
    b2     <= b1;
    acadd2 <= a1[COEF_W-1] != c1[COEF_W-1];
    bb_lo  <= PROD_W'(bm1 * bm1[HALF_W-1:0]);
    bb_hi  <= PROD_W'(bm1 * bm1[COEF_W-2:HALF_W]);
    ac_lo  <= PROD_W'(am1 * cm1[HALF_W-1:0]);
    ac_hi  <= PROD_W'(am1 * cm1[COEF_W-2:HALF_W]);
  end

  // stage 3: discriminant and classification
  logic                     v3;
  logic signed [COEF_W-1:0] a3, b3;
  logic [1:0]               st3;
  logic [P_W-2:0]           p3;
  logic [P_W-1:0]           bsq, acp, t3b, pv, pl;
  logic [1:0]               st_next;

  always_comb begin
    bsq = P_W'(bb_lo) + (P_W'(bb_hi) << HALF_W);
    acp = P_W'(ac_lo) + (P_W'(ac_hi) << HALF_W);
    t3b = bsq + (bsq << 1);
    pv  = acadd2 ? t3b + acp : t3b - acp;
    pl  = pv + (P_W'(3) << (2 * FRAC_BITS));
    if (a2 == '0)          st_next = ST_FLAT;
    else if (pl[P_W-1])    st_next = ST_COMPLEX;
    else                   st_next = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    a3  <= a2;
    b3  <= b2;
    st3 <= st_next;
    p3  <= pv[P_W-1] ? '0 : pv[P_W-2:0];
  end

  // stage 4 and square root: 3 * root^2 <= p * 2^(2F), one bit per stage
  logic                     sq_v    [0:SQRT_STEPS];
  logic [1:0]               sq_st   [0:SQRT_STEPS];
  logic signed [COEF_W-1:0] sq_a    [0:SQRT_STEPS];
  logic signed [COEF_W-1:0] sq_b    [0:SQRT_STEPS];
  logic [SQ_W-1:0]          sq_rem  [0:SQRT_STEPS];
  logic [ROOT_W-1:0]        sq_root [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else     sq_v[0] <= v3;
  end

  always_ff @(posedge clk) begin
    sq_st[0]   <= st3;
    sq_a[0]    <= a3;
    sq_b[0]    <= b3;
    sq_rem[0]  <= SQ_W'(p3) << (2 * FRAC_BITS);
    sq_root[0] <= '0;
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    localparam int K = SQRT_STEPS - 1 - i;
    logic [SQ_W-1:0] trm, t3;
    logic            ge;

    always_comb begin
      trm = (SQ_W'(sq_root[i]) << (K + 1)) | (SQ_W'(1) << (2 * K));
      t3  = trm + (trm << 1);
      ge  = sq_rem[i] >= t3;
    end

    always_ff @(posedge clk) begin
      if (rst) sq_v[i+1] <= 1'b0;
      else     sq_v[i+1] <= sq_v[i];
    end

    always_ff @(posedge clk) begin
      sq_st[i+1]   <= sq_st[i];
      sq_a[i+1]    <= sq_a[i];
      sq_b[i+1]    <= sq_b[i];
      sq_rem[i+1]  <= ge ? sq_rem[i] - t3 : sq_rem[i];
      sq_root[i+1] <= sq_root[i] | (ROOT_W'(ge) << K);
    end
  end

  // numerator and operand magnitudes
  logic signed [NUM_W-1:0] bx, nv, nn;
  logic signed [COEF_W-1:0] an;

  always_comb begin
    bx = NUM_W'(sq_b[SQRT_STEPS]);
    nv = -(bx <<< FRAC_BITS) - $signed(NUM_W'(sq_root[SQRT_STEPS]));
    nn = -nv;
    an = -sq_a[SQRT_STEPS];
  end

  logic             dv_v    [0:DIV_STEPS];
  logic [1:0]       dv_st   [0:DIV_STEPS];
  logic             dv_neg  [0:DIV_STEPS];
  logic [DEN_W-1:0] dv_den  [0:DIV_STEPS];
  logic [DEN_W-1:0] dv_rem  [0:DIV_STEPS];
  logic [NUM_W-1:0] dv_num  [0:DIV_STEPS];
  logic [NUM_W-1:0] dv_q    [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else     dv_v[0] <= sq_v[SQRT_STEPS];
  end

  always_ff @(posedge clk) begin
    dv_st[0]  <= sq_st[SQRT_STEPS];
    dv_neg[0] <= nv[NUM_W-1] ^ sq_a[SQRT_STEPS][COEF_W-1];
    dv_den[0] <= sq_a[SQRT_STEPS][COEF_W-1] ? DEN_W'(an) : DEN_W'(sq_a[SQRT_STEPS]);
    dv_num[0] <= nv[NUM_W-1] ? nn : nv;
    dv_rem[0] <= '0;
    dv_q[0]   <= '0;
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [DEN_W-1:0] trial;
    logic             ge;

    always_comb begin
      trial = {dv_rem[j][DEN_W-2:0], dv_num[j][NUM_W-1]};
      ge    = trial >= dv_den[j];
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else     dv_v[j+1] <= dv_v[j];
    end

    always_ff @(posedge clk) begin
      dv_st[j+1]  <= dv_st[j];
      dv_neg[j+1] <= dv_neg[j];
      dv_den[j+1] <= dv_den[j];
      dv_rem[j+1] <= ge ? trial - dv_den[j] : trial;
      dv_num[j+1] <= dv_num[j] << 1;
      dv_q[j+1]   <= {dv_q[j][NUM_W-2:0], ge};
    end
  end

  // saturation and output register
  logic [NUM_W-1:0]    qf;
  logic [SAMPLE_W-1:0] qn, off_next;

  always_comb begin
    qf = dv_q[DIV_STEPS];
    qn = -qf[SAMPLE_W-1:0];
    if (dv_st[DIV_STEPS] != ST_OK)
      off_next = '0;
    else if (!dv_neg[DIV_STEPS])
      off_next = (qf > NUM_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : qf[SAMPLE_W-1:0];
    else
      off_next = (qf > NUM_W'(32'h8000_0000)) ? 32'h8000_0000 : qn;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv_v[DIV_STEPS];
  end

  always_ff @(posedge clk) begin
    result.peak_offset <= off_next;
    result.fit_status  <= dv_st[DIV_STEPS];
  end

endmodule

@@ rtl/core/cpi_checker.sv @@
// -----------------------------------------------------------------------------
// Cubic peak interpolator checker
// Port-level properties of the pipeline, bound to the top level.
// -----------------------------------------------------------------------------
`include "cubic_peak_interpolator_unit_macros.svh"

module cpi_checker
  import cpi_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input samples_t samples,
  input result_t  result,
  input logic     done
);

  logic flat_in, status_legal;

  assign flat_in = start && !busy &&
                   samples.sample_0 == samples.sample_1 &&
                   samples.sample_1 == samples.sample_2 &&
                   samples.sample_2 == samples.sample_3;
  assign status_legal = result.fit_status inside {ST_OK, ST_FLAT, ST_COMPLEX};

  `CPI_ASSERT_DELAY(a_latency, clk, rst, start && !busy, LATENCY, done)
  `CPI_ASSERT_DELAY(a_flat, clk, rst, flat_in, LATENCY, result.fit_status == ST_FLAT)
  `CPI_ASSERT_IMPLY(a_fail_zero, clk, rst, done && result.fit_status != ST_OK, result.peak_offset == '0)
  `CPI_ASSERT_IMPLY(a_status_code, clk, rst, done, status_legal)

endmodule

bind cubic_peak_interpolator_unit cpi_checker u_cpi_checker (.*);

@@ tb/tb.sv @@
// -----------------------------------------------------------------------------
// Cubic peak interpolator testbench
// Drives sample sets through start/busy, predicts peak offset and fit status
// with exact wide integer arithmetic, and checks every strobed result in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import cpi_pkg::*;

  localparam int F = FRAC_BITS_DEF;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  samples_t samples;
  result_t  result;
  logic     done;

  samples_t pending_q[$];
  result_t  expected_q[$];
  int       errors = 0;
  int       txn_count = 0;
  int       hold_at;
  int       no_idle_lo;
  int       no_idle_hi;
  logic     busy_q;

  cubic_peak_interpolator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .samples(samples), .result(result), .done(done)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic result_t predict_peak(samples_t s);
    result_t r;
    logic signed [63:0] s0, s1, s2, s3, a6, b, c6, num, x;
    logic signed [159:0] p, m, lim, sq;
    logic [63:0] root, cand;
    s0 = s.sample_0; s1 = s.sample_1; s2 = s.sample_2; s3 = s.sample_3;
    a6 = -s0 + 3 * s1 - 3 * s2 + s3;
    b = 2 * s0 - 5 * s1 + 4 * s2 - s3;
    c6 = -11 * s0 + 18 * s1 - 9 * s2 + 2 * s3;
    r.peak_offset = '0;
    if (a6 == 0) begin
      r.fit_status = ST_FLAT;
      return r;
    end
    p = 160'(3) * 160'(b) * 160'(b) - 160'(a6) * 160'(c6);
    lim = 160'(3) <<< (2 * F);
    if (p < 0) begin
      if (p + lim < 0) begin
        r.fit_status = ST_COMPLEX;
        return r;
      end
      p = '0;
    end
    m = p <<< (2 * F);
    root = '0;
    for (int i = 60; i >= 0; i--) begin
      cand = root | (64'd1 << i);
      sq = 160'(cand) * 160'(cand);
      if (3 * sq <= m) root = cand;
    end
    num = -(b <<< F) - $signed(root);
    x = num / a6;
    if (x > 64'sh7fffffff) x = 64'sh7fffffff;
    if (x < -64'sh80000000) x = -64'sh80000000;
    r.peak_offset = x[31:0];
    r.fit_status = ST_OK;
    return r;
  endfunction

  function automatic logic [31:0] rand_sample(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< F;
      2: return 32'($signed($urandom_range(0, 65535)) - 32768);
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) <<< 4;
    endcase
  endfunction

  function automatic samples_t peak_set();
    samples_t s;
    int base, h;
    base = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    h = $urandom_range(1, 1 << 20);
    s.sample_0 = base + $signed($urandom_range(0, 1 << 18));
    s.sample_1 = base + h + $signed($urandom_range(0, h));
    s.sample_2 = base + h + $signed($urandom_range(0, h));
    s.sample_3 = base + $signed($urandom_range(0, 1 << 18));
    return s;
  endfunction

  function automatic samples_t mk(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                  logic [31:0] d);
    samples_t s;
    s.sample_0 = a; s.sample_1 = b; s.sample_2 = c; s.sample_3 = d;
    return s;
  endfunction

  task automatic add_item(input samples_t s);
    pending_q = {pending_q, s};
  endtask

  initial begin
    samples_t s;
    int mode;
    // directed: extremes, flat, complex, clamped discriminant, saturation
    add_item(mk(0, 0, 0, 0));
    add_item(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    add_item(mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
    add_item(mk(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    add_item(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
    add_item(mk(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    add_item(mk(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff));
    add_item(mk(32'hffffffff, 32'h1, 32'hffffffff, 32'h1));
    add_item(mk(0, 3 << F, 4 << F, 0));
    add_item(mk(0, 1 << F, 2 << F, 3 << F));
    add_item(mk(0, 1, 4, 9));
    add_item(mk(0, 0, 0, 1));
    add_item(mk(0, 0, 0, 32'hffffffff));
    add_item(mk(0, 0, 0, 6));
    add_item(mk(0, 1, 0, 0));
    add_item(mk(0, 0, 1, 0));
    add_item(mk(0, 0, 0, 32'h7fffffff));
    add_item(mk(0, 0, 1, 3));
    add_item(mk(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa));
    add_item(mk(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555));
    add_item(mk(0, 32'h7fffffff, 32'h7fffffff, 32'h7ffffffe));
    for (int i = 0; i < 1650; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) s = peak_set();
      else if (mode == 6) s = mk(0, 0, 0, 32'($signed($urandom_range(0, 20)) - 10));
      else s = mk(rand_sample(mode - 7), rand_sample($urandom_range(0, 3)),
                  rand_sample($urandom_range(0, 3)), rand_sample(mode - 6));
      add_item(s);
    end
    hold_at = 700;
    no_idle_lo = 300;
    no_idle_hi = 550;
  end

  initial begin
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  always @(posedge clk) busy_q <= busy;

  // driver: retire the accepted transaction, then decide the next drive
  always @(negedge clk) begin
    bit idle;
    if (rst) begin
      start <= 1'b0;
      samples <= '0;
    end else begin
      if (start && !busy_q) begin
        pending_q.delete(0);
        txn_count++;
      end
      idle = ($urandom_range(0, 99) < 27) &&
             !(txn_count >= no_idle_lo && txn_count < no_idle_hi);
      if (txn_count == hold_at && expected_q.size() != 0) idle = 1'b1;
      if (pending_q.size() == 0 || idle) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        samples <= pending_q[0];
      end
    end
  end

  // acceptance and checking
  always @(posedge clk) begin
    result_t e;
    if (!rst) begin
      if (start && !busy) expected_q = {expected_q, predict_peak(samples)};
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (result.peak_offset !== e.peak_offset) begin
            $error("peak_offset expected %0d actual %0d", e.peak_offset, result.peak_offset);
            errors++;
          end
          if (result.fit_status !== e.fit_status) begin
            $error("fit_status expected %0d actual %0d", e.fit_status, result.fit_status);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (!rst);
    while (pending_q.size() != 0 || start) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/cpi_pkg.sv
rtl/core/cubic_peak_interpolator_unit.sv
rtl/core/cpi_checker.sv
tb/tb.sv
